### sv/omt_pkg.sv
// ----------------------------------------------------------------------------
// omt_pkg: shared definitions for the owned mutex table
// Opcodes, status codes, fixed field widths and the table command bundle.
// ----------------------------------------------------------------------------
package omt_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int ID_BITS_DEF = 16;

    localparam int OPCODE_BITS = 3;
    localparam int MID_BITS    = 16;
    localparam int PROC_BITS   = 16;
    localparam int STATUS_BITS = 3;
    localparam int NEWID_BITS  = 16;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    localparam logic [OPCODE_BITS-1:0] OP_CREATE  = 3'd0;
    localparam logic [OPCODE_BITS-1:0] OP_ACQUIRE = 3'd1;
    localparam logic [OPCODE_BITS-1:0] OP_RELEASE = 3'd2;
    localparam logic [OPCODE_BITS-1:0] OP_DELETE  = 3'd3;
    localparam logic [OPCODE_BITS-1:0] OP_PURGE   = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND   = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL        = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_BUSY        = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NOT_HOLDER  = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_NOT_CREATOR = 3'd5;

    // Strobes from the sequencer to the entry table.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_en;
    } t_tbl_cmd;

endpackage

### sv/owned_mutex_table_core.sv
// ----------------------------------------------------------------------------
// owned_mutex_table_core: table of owned mutexes
// Create, acquire, release, delete and purge requests against ENTRIES slots.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel, one transaction per request:
//   opcode, mutex id and process id packed in tdata. Every request yields
//   exactly one response transaction on m_axis: status and new id.
//   A request is served by a sequencer that walks the table one entry per
//   cycle through a single comparator, reading a memory with a registered
//   read port. Create, acquire, release and delete stop at the first
//   matching entry (a free slot for create) and do at most one
//   read-modify-write or clear; purge walks every entry and clears each
//   one whose creator matches. An unknown opcode skips the walk and
//   answers not found. tready stays low while a request is in progress
//   and rises in the same cycle that the response is loaded. The
//   response sits in an output register; the next request is
//   accepted while it waits, but that request cannot finish until the
//   receiver takes the previous response. Reset empties the table at once
//   through per-entry valid bits and sets the id counter to one.
// ----------------------------------------------------------------------------
module owned_mutex_table_core #(
    parameter int ENTRIES = omt_pkg::ENTRIES_DEF,
    parameter int ID_BITS = omt_pkg::ID_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [2:0] opcode, [18:3] mutex_id, [34:19] proc_id, [39:35] zero
    input  logic [omt_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [2:0] status, [18:3] new_id, [23:19] zero
    output logic [omt_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int PB     = omt_pkg::PROC_BITS;
    localparam int DATA_W = ID_BITS + 1 + 2 * PB;
    localparam int LK_POS = 2 * PB;
    localparam int ID_LO  = 2 * PB + 1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [omt_pkg::OPCODE_BITS-1:0] r_op, n_op;
    logic [ID_BITS-1:0] r_mid, n_mid;
    logic [PB-1:0] r_pid, n_pid;
    logic [CNT_W-1:0] r_issue_cnt, n_issue_cnt;
    logic r_pend, n_pend;
    logic [IDX_W-1:0] r_pend_idx, n_pend_idx;
    logic [IDX_W-1:0] r_hit_idx, n_hit_idx;
    logic [DATA_W-1:0] r_hit_data, n_hit_data;
    logic [omt_pkg::STATUS_BITS-1:0] r_status, n_status;
    logic [ID_BITS-1:0] r_given, n_given;
    logic [ID_BITS-1:0] r_next_id, n_next_id;
    logic r_out_valid, n_out_valid;
    logic [omt_pkg::STATUS_BITS-1:0] r_out_status, n_out_status;
    logic [omt_pkg::NEWID_BITS-1:0] r_out_new_id, n_out_new_id;

    omt_pkg::t_tbl_cmd tbl_cmd;
    logic [IDX_W-1:0] w_rd_addr, w_wr_addr, w_clr_addr;
    logic [DATA_W-1:0] w_wr_data, w_rd_data;
    logic w_rd_valid;

    logic [31:0] w_mid32;
    logic [31:0] w_given32;
    logic [ID_BITS-1:0] w_next_inc;
    logic [ID_BITS-1:0] w_rd_id;
    logic [PB-1:0] w_rd_creator;
    logic w_hit_locked;
    logic [PB-1:0] w_hit_holder, w_hit_creator;
    logic w_hit;

    omt_table #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W),
        .DATA_W  (DATA_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (tbl_cmd),
        .i_rd_addr  (w_rd_addr),
        .i_wr_addr  (w_wr_addr),
        .i_wr_data  (w_wr_data),
        .i_clr_addr (w_clr_addr),
        .o_rd_data  (w_rd_data),
        .o_rd_valid (w_rd_valid)
    );

    assign w_mid32       = {16'b0, i_s_axis_tdata[18:3]};
    assign w_given32     = 32'(r_given);
    assign w_next_inc    = r_next_id + ID_BITS'(1);
    assign w_rd_id       = w_rd_data[DATA_W-1:ID_LO];
    assign w_rd_creator  = w_rd_data[PB-1:0];
    assign w_hit_locked  = r_hit_data[LK_POS];
    assign w_hit_holder  = r_hit_data[2*PB-1:PB];
    assign w_hit_creator = r_hit_data[PB-1:0];

    // Create looks for a free slot; the single-entry ops look for the id; purge never hits.
    always_comb begin
        if (r_op == omt_pkg::OP_CREATE) begin
            w_hit = r_pend && !w_rd_valid;
        end else if (r_op == omt_pkg::OP_PURGE) begin
            w_hit = 1'b0;
        end else begin
            w_hit = r_pend && w_rd_valid && (r_mid != '0) && (w_rd_id == r_mid);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_mid        = r_mid;
        n_pid        = r_pid;
        n_issue_cnt  = r_issue_cnt;
        n_pend       = r_pend;
        n_pend_idx   = r_pend_idx;
        n_hit_idx    = r_hit_idx;
        n_hit_data   = r_hit_data;
        n_status     = r_status;
        n_given      = r_given;
        n_next_id    = r_next_id;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_new_id = r_out_new_id;
        tbl_cmd      = '0;
        w_rd_addr    = r_issue_cnt[IDX_W-1:0];
        w_wr_addr    = r_hit_idx;
        w_wr_data    = r_hit_data;
        w_clr_addr   = r_pend_idx;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_op        = i_s_axis_tdata[2:0];
                    n_mid       = w_mid32[ID_BITS-1:0];
                    n_pid       = i_s_axis_tdata[34:19];
                    n_issue_cnt = '0;
                    n_pend      = 1'b0;
                    n_given     = '0;
                    n_status    = omt_pkg::ST_OK;
                    if (i_s_axis_tdata[2:0] > omt_pkg::OP_PURGE) begin
                        n_status = omt_pkg::ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_hit_idx  = r_pend_idx;
                    n_hit_data = w_rd_data;
                    n_pend     = 1'b0;
                    n_state    = S_UPDATE;
                end else if (!r_pend && r_issue_cnt == CNT_W'(ENTRIES)) begin
                    if (r_op == omt_pkg::OP_CREATE) begin
                        n_status = omt_pkg::ST_FULL;
                    end else if (r_op == omt_pkg::OP_PURGE) begin
                        n_status = omt_pkg::ST_OK;
                    end else begin
                        n_status = omt_pkg::ST_NOT_FOUND;
                    end
                    n_state = S_DONE;
                end else begin
                    if (r_op == omt_pkg::OP_PURGE && r_pend && w_rd_valid
                            && w_rd_creator == r_pid) begin
                        tbl_cmd.clr_en = 1'b1;
                    end
                    if (r_issue_cnt != CNT_W'(ENTRIES)) begin
                        tbl_cmd.rd_en = 1'b1;
                        n_issue_cnt   = r_issue_cnt + CNT_W'(1);
                        n_pend        = 1'b1;
                        n_pend_idx    = r_issue_cnt[IDX_W-1:0];
                    end else begin
                        n_pend = 1'b0;
                    end
                end
            end
            S_UPDATE: begin
                n_state = S_DONE;
                case (r_op)
                    omt_pkg::OP_CREATE: begin
                        w_wr_data     = {r_next_id, 1'b0, {PB{1'b0}}, r_pid};
                        tbl_cmd.wr_en = 1'b1;
                        n_given       = r_next_id;
                        n_next_id     = (w_next_inc == '0) ? ID_BITS'(1) : w_next_inc;
                        n_status      = omt_pkg::ST_OK;
                    end
                    omt_pkg::OP_ACQUIRE: begin
                        if (w_hit_locked) begin
                            n_status = omt_pkg::ST_BUSY;
                        end else begin
                            w_wr_data     = {r_hit_data[DATA_W-1:ID_LO], 1'b1, r_pid,
                                             w_hit_creator};
                            tbl_cmd.wr_en = 1'b1;
                            n_status      = omt_pkg::ST_OK;
                        end
                    end
                    omt_pkg::OP_RELEASE: begin
                        if (w_hit_locked && w_hit_holder == r_pid) begin
                            w_wr_data     = {r_hit_data[DATA_W-1:ID_LO], 1'b0,
                                             {PB{1'b0}}, w_hit_creator};
                            tbl_cmd.wr_en = 1'b1;
                            n_status      = omt_pkg::ST_OK;
                        end else begin
                            n_status = omt_pkg::ST_NOT_HOLDER;
                        end
                    end
                    omt_pkg::OP_DELETE: begin
                        if (w_hit_creator != r_pid) begin
                            n_status = omt_pkg::ST_NOT_CREATOR;
                        end else begin
                            w_clr_addr     = r_hit_idx;
                            tbl_cmd.clr_en = 1'b1;
                            n_status       = omt_pkg::ST_OK;
                        end
                    end
                    default: begin
                        n_status = omt_pkg::ST_NOT_FOUND;
                    end
                endcase
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_new_id = w_given32[omt_pkg::NEWID_BITS-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue_cnt <= '0;
            r_pend      <= 1'b0;
            r_next_id   <= ID_BITS'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issue_cnt <= n_issue_cnt;
            r_pend      <= n_pend;
            r_next_id   <= n_next_id;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_mid        <= n_mid;
        r_pid        <= n_pid;
        r_pend_idx   <= n_pend_idx;
        r_hit_idx    <= n_hit_idx;
        r_hit_data   <= n_hit_data;
        r_status     <= n_status;
        r_given      <= n_given;
        r_out_status <= n_out_status;
        r_out_new_id <= n_out_new_id;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_new_id, r_out_status};

    // The id counter never hands out the free marker.
    a_next_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id != '0)
        else $error("id counter reached zero");

    // A nonzero id is only ever reported with a successful create.
    a_new_id_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[18:3] != '0) |->
        (o_m_axis_tdata[2:0] == omt_pkg::ST_OK))
        else $error("new id reported with a failing status");

    // A new response is only ever loaded from the done state.
    a_resp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_DONE))
        else $error("response appeared outside the done state");

    // The update state always advances straight to the done state.
    a_update_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |=> (r_state == S_DONE))
        else $error("update did not advance to done");

endmodule

### sv/omt_table.sv
// ----------------------------------------------------------------------------
// omt_table: mutex entry storage
// One-port-write, one-port-read memory of entries with registered read data,
// plus a valid bit per entry that reset clears. A clear frees an entry.
// ----------------------------------------------------------------------------
module omt_table #(
    parameter int ENTRIES = omt_pkg::ENTRIES_DEF,
    parameter int IDX_W   = 4,
    parameter int DATA_W  = 49
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  omt_pkg::t_tbl_cmd   i_cmd,
    input  logic [IDX_W-1:0]    i_rd_addr,
    input  logic [IDX_W-1:0]    i_wr_addr,
    input  logic [DATA_W-1:0]   i_wr_data,
    input  logic [IDX_W-1:0]    i_clr_addr,
    output logic [DATA_W-1:0]   o_rd_data,
    output logic                o_rd_valid
);

    logic [DATA_W-1:0] r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [DATA_W-1:0] r_rd_data;
    logic r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_cmd.clr_en) begin
                r_valid[i_clr_addr] <= 1'b0;
            end
            if (i_cmd.rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_rd_valid = r_rd_valid;

endmodule
